// File: design/tcc_pkg.sv
// ----------------------------------------------------------------------------
// Text console character writer package
// Shared types, constants and the Latin-1 to CP437 character map.
// ----------------------------------------------------------------------------
package tcc_pkg;

  // Default geometry of the console.
  localparam int DEF_COLUMNS   = 80;
  localparam int DEF_ROWS      = 25;
  localparam int DEF_TAB_WIDTH = 4;

  // Cell written by reset and by the clear operation: a space with attribute 07.
  localparam logic [15:0] BLANK_CELL = 16'h0720;
  localparam logic [7:0]  CH_SPACE   = 8'h20;
  localparam logic [7:0]  CH_NUL     = 8'h00;
  localparam logic [7:0]  CH_BS      = 8'h08;
  localparam logic [7:0]  CH_TAB     = 8'h09;
  localparam logic [7:0]  CH_LF      = 8'h0A;
  localparam logic [7:0]  CH_CR      = 8'h0D;

  // Operation codes of a request.
  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  // Class of a mapped character.
  typedef enum logic [2:0] {
    CLS_NUL,
    CLS_LF,
    CLS_CR,
    CLS_BS,
    CLS_TAB,
    CLS_PRINT
  } char_cls_t;

  // Cell store access for one cycle.
  typedef enum logic [2:0] {
    MEM_NONE,
    MEM_PUT,
    MEM_ERASE,
    MEM_READ,
    MEM_FILL,
    MEM_COPY_RD,
    MEM_COPY_WR,
    MEM_BLANK
  } mem_cmd_t;

  // Cursor update for one cycle.
  typedef enum logic [2:0] {
    CUR_NONE,
    CUR_ADVANCE,
    CUR_NEWLINE,
    CUR_CR,
    CUR_BACK,
    CUR_HOME
  } cur_cmd_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     load;
    mem_cmd_t mem;
    cur_cmd_t cur;
    logic     cnt_clr;
    logic     cnt_inc;
    logic     capture;
    logic     shown_load;
    logic     shown_clr;
  } tcc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    op_t       op;
    char_cls_t cls;
    logic      last;
    logic      at_right;
    logic      at_bottom;
    logic      tab_end;
    logic      copy_last;
    logic      cnt_end;
  } tcc_status_t;

  // Accented Latin-1 codes to their CP437 equivalents.
  function automatic logic [7:0] map_latin1(input logic [7:0] c);
    logic [7:0] m;
    case (c)
      8'hE2:   m = 8'h83;
      8'hE4:   m = 8'h84;
      8'hE0:   m = 8'h85;
      8'hE9:   m = 8'h82;
      8'hEA:   m = 8'h88;
      8'hEB:   m = 8'h89;
      8'hE8:   m = 8'h8A;
      8'hEF:   m = 8'h8B;
      8'hEE:   m = 8'h8C;
      8'hF4:   m = 8'h93;
      8'hF6:   m = 8'h94;
      8'hFB:   m = 8'h96;
      8'hFC:   m = 8'h81;
      default: m = c;
    endcase
    return m;
  endfunction

  // Control code class of a mapped character.
  function automatic char_cls_t classify(input logic [7:0] c);
    char_cls_t k;
    case (c)
      CH_NUL:  k = CLS_NUL;
      CH_LF:   k = CLS_LF;
      CH_CR:   k = CLS_CR;
      CH_BS:   k = CLS_BS;
      CH_TAB:  k = CLS_TAB;
      default: k = CLS_PRINT;
    endcase
    return k;
  endfunction

endpackage

// File: design/tcc_ctrl.sv
// ----------------------------------------------------------------------------
// Text console controller
// State machine that sequences each request over the datapath.
// ----------------------------------------------------------------------------
module tcc_ctrl
  import tcc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  tcc_status_t status,
  output tcc_cmd_t    cmd,
  output logic        busy,
  output logic        done
);

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_DECODE,
    ST_PRINT,
    ST_ERASE,
    ST_READ_WAIT,
    ST_CLEAR,
    ST_SCR_RD,
    ST_SCR_WR,
    ST_SCR_BLANK,
    ST_FINISH
  } state_t;

  state_t state;
  state_t state_next;
  logic   done_next;

  assign busy = (state != ST_IDLE);

  // Next state and command decode.
  always_comb begin
    state_next = state;
    done_next  = 1'b0;
    cmd        = '0;
    cmd.mem    = MEM_NONE;
    cmd.cur    = CUR_NONE;
    case (state)
      ST_INIT: begin
        cmd.mem     = MEM_FILL;
        cmd.cnt_inc = 1'b1;
        if (status.cnt_end) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        cmd.cnt_clr = 1'b1;
        case (status.op)
          OP_READ: begin
            cmd.mem    = MEM_READ;
            state_next = ST_READ_WAIT;
          end
          OP_CLEAR: begin
            state_next = ST_CLEAR;
          end
          OP_PUT: begin
            case (status.cls)
              CLS_NUL: begin
                state_next = ST_FINISH;
              end
              CLS_LF: begin
                cmd.cur    = CUR_NEWLINE;
                state_next = status.at_bottom ? ST_SCR_RD : ST_FINISH;
              end
              CLS_CR: begin
                cmd.cur    = CUR_CR;
                state_next = ST_FINISH;
              end
              CLS_BS: begin
                cmd.cur    = CUR_BACK;
                state_next = ST_ERASE;
              end
              default: begin
                state_next = ST_PRINT;
              end
            endcase
          end
          default: begin
            state_next = ST_FINISH;
          end
        endcase
      end
      ST_PRINT: begin
        // Write the cell, then wrap, scroll or repeat for a tab.
        cmd.mem     = MEM_PUT;
        cmd.cur     = CUR_ADVANCE;
        cmd.cnt_clr = 1'b1;
        if (status.at_right) begin
          state_next = status.at_bottom ? ST_SCR_RD : ST_FINISH;
        end else if (status.cls == CLS_TAB && !status.tab_end) begin
          state_next = ST_PRINT;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_ERASE: begin
        cmd.mem    = MEM_ERASE;
        state_next = ST_FINISH;
      end
      ST_READ_WAIT: begin
        cmd.capture = 1'b1;
        state_next  = ST_FINISH;
      end
      ST_CLEAR: begin
        cmd.mem     = MEM_FILL;
        cmd.cnt_inc = 1'b1;
        if (status.cnt_end) begin
          cmd.cur       = CUR_HOME;
          cmd.shown_clr = 1'b1;
          state_next    = ST_FINISH;
        end
      end
      ST_SCR_RD: begin
        cmd.mem    = MEM_COPY_RD;
        state_next = ST_SCR_WR;
      end
      ST_SCR_WR: begin
        cmd.mem     = MEM_COPY_WR;
        cmd.cnt_inc = 1'b1;
        state_next  = status.copy_last ? ST_SCR_BLANK : ST_SCR_RD;
      end
      ST_SCR_BLANK: begin
        cmd.mem     = MEM_BLANK;
        cmd.cnt_inc = 1'b1;
        if (status.cnt_end) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        cmd.shown_load = (status.op == OP_PUT) && status.last;
        done_next      = 1'b1;
        state_next     = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State and result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

endmodule

// File: design/tcc_dp.sv
// ----------------------------------------------------------------------------
// Text console datapath
// Cell store, cursor, displayed cursor, sweep counter and result register.
// ----------------------------------------------------------------------------
module tcc_dp
  import tcc_pkg::*;
#(
  parameter int COLUMNS   = DEF_COLUMNS,
  parameter int ROWS      = DEF_ROWS,
  parameter int TAB_WIDTH = DEF_TAB_WIDTH
) (
  input  logic        clk,
  input  logic        rst,
  input  tcc_cmd_t    cmd,
  output tcc_status_t status,
  input  logic [1:0]  operation,
  input  logic [7:0]  char_code,
  input  logic [10:0] cell_index,
  input  logic        last_of_call,
  input  logic [3:0]  fore_color,
  input  logic [3:0]  back_color,
  output logic [15:0] cell_value,
  output logic [6:0]  shown_col,
  output logic [4:0]  shown_row
);

  localparam int CELLS      = COLUMNS * ROWS;
  localparam int COPY_CELLS = COLUMNS * (ROWS - 1);
  localparam int CW         = $clog2(COLUMNS);
  localparam int RW         = $clog2(ROWS);
  localparam int AW         = $clog2(CELLS);
  localparam int PW         = (TAB_WIDTH > 1) ? $clog2(TAB_WIDTH) : 1;
  localparam int LAST_PHASE = (COLUMNS - 1) % TAB_WIDTH;

  // Latched request.
  op_t         op;
  logic [7:0]  chr;
  logic [10:0] index;
  logic        last;
  logic        in_range;

  // Cursor, tab phase, displayed cursor and sweep counter.
  logic [CW-1:0] cursor_col;
  logic [RW-1:0] cursor_row;
  logic [PW-1:0] phase;
  logic [CW-1:0] disp_col;
  logic [RW-1:0] disp_row;
  logic [AW-1:0] cnt;

  // Cell store.
  logic [15:0]   mem [CELLS];
  logic [15:0]   rd_data;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [15:0]   wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;

  logic [AW-1:0] cur_addr;
  logic [7:0]    attr;
  logic [7:0]    print_ch;
  logic          at_right;
  logic          at_bottom;

  assign attr      = {back_color, fore_color};
  assign print_ch  = (chr == CH_TAB) ? CH_SPACE : chr;
  assign cur_addr  = AW'(cursor_row) * AW'(COLUMNS) + AW'(cursor_col);
  assign at_right  = (cursor_col == CW'(COLUMNS - 1));
  assign at_bottom = (cursor_row == RW'(ROWS - 1));
  assign in_range  = ({21'd0, index} < 32'(CELLS));

  // Status towards the controller.
  always_comb begin
    status.op        = op;
    status.cls       = classify(chr);
    status.last      = last;
    status.at_right  = at_right;
    status.at_bottom = at_bottom;
    status.tab_end   = (phase == PW'(TAB_WIDTH - 1));
    status.copy_last = (cnt == AW'(COPY_CELLS - 1));
    status.cnt_end   = (cnt == AW'(CELLS - 1));
  end

  // Store access selection.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cnt;
    wr_data = BLANK_CELL;
    rd_en   = 1'b0;
    rd_addr = AW'(index);
    case (cmd.mem)
      MEM_PUT: begin
        wr_en   = 1'b1;
        wr_addr = cur_addr;
        wr_data = {attr, print_ch};
      end
      MEM_ERASE: begin
        wr_en   = 1'b1;
        wr_addr = cur_addr;
        wr_data = {attr, CH_SPACE};
      end
      MEM_READ: begin
        rd_en = in_range;
      end
      MEM_FILL: begin
        wr_en = 1'b1;
      end
      MEM_COPY_RD: begin
        rd_en   = 1'b1;
        rd_addr = AW'(cnt + AW'(COLUMNS));
      end
      MEM_COPY_WR: begin
        wr_en   = 1'b1;
        wr_data = rd_data;
      end
      MEM_BLANK: begin
        wr_en   = 1'b1;
        wr_data = {attr, CH_SPACE};
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // Cell store with registered read data.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Request capture and result value.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op    <= op_t'(operation);
      chr   <= map_latin1(char_code);
      index <= cell_index;
      last  <= last_of_call;
    end
    if (cmd.load) begin
      cell_value <= '0;
    end else if (cmd.capture) begin
      cell_value <= in_range ? rd_data : 16'd0;
    end
  end

  // Sweep counter for clearing and scrolling.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.cnt_clr) begin
      cnt <= '0;
    end else if (cmd.cnt_inc) begin
      cnt <= cnt + AW'(1);
    end
  end

  // Cursor movement; the phase tracks the column modulo the tab width.
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_col <= '0;
      cursor_row <= '0;
      phase      <= '0;
    end else begin
      case (cmd.cur)
        CUR_ADVANCE, CUR_NEWLINE: begin
          if (cmd.cur == CUR_ADVANCE && !at_right) begin
            cursor_col <= cursor_col + CW'(1);
            phase      <= (phase == PW'(TAB_WIDTH - 1)) ? '0 : phase + PW'(1);
          end else begin
            cursor_col <= '0;
            phase      <= '0;
            if (!at_bottom) begin
              cursor_row <= cursor_row + RW'(1);
            end
          end
        end
        CUR_CR: begin
          cursor_col <= '0;
          phase      <= '0;
        end
        CUR_BACK: begin
          if (cursor_col == '0) begin
            if (cursor_row != '0) begin
              cursor_row <= cursor_row - RW'(1);
              cursor_col <= CW'(COLUMNS - 1);
              phase      <= PW'(LAST_PHASE);
            end
          end else begin
            cursor_col <= cursor_col - CW'(1);
            phase      <= (phase == '0) ? PW'(TAB_WIDTH - 1) : phase - PW'(1);
          end
        end
        CUR_HOME: begin
          cursor_col <= '0;
          cursor_row <= '0;
          phase      <= '0;
        end
        default: begin
          cursor_col <= cursor_col;
        end
      endcase
    end
  end

  // Displayed cursor.
  always_ff @(posedge clk) begin
    if (rst) begin
      disp_col <= '0;
      disp_row <= '0;
    end else if (cmd.shown_clr) begin
      disp_col <= '0;
      disp_row <= '0;
    end else if (cmd.shown_load) begin
      disp_col <= cursor_col;
      disp_row <= cursor_row;
    end
  end

  assign shown_col = 7'(disp_col);
  assign shown_row = 5'(disp_row);

endmodule

// File: design/text_console_character_writer_core.sv
// ----------------------------------------------------------------------------
// Text console character writer
// Character-cell console with cursor, wrap, scroll and control codes.
// ----------------------------------------------------------------------------
// Channel   Signals                                          Direction
// request   start, busy, operation, char_code, cell_index,   in (busy out)
//           last_of_call
// result    done, cell_value, shown_col, shown_row           out
// config    psel, penable, pwrite, paddr, pwdata, prdata,    in / out
//           pready
//
// A request is accepted only while busy is low, so the block takes no new
// request until it has finished the last one. A tab writes spaces up to the
// next tab stop or the right edge. A scroll copies each cell of the moved
// rows up by a read and then a write, then blanks the bottom row. A clear
// fills every cell with a blank and homes the cursor. After reset the store
// is cleared one cell a cycle, with busy high. Results are strobed for one
// cycle and cannot be stalled.
// ----------------------------------------------------------------------------
module text_console_character_writer_core
  import tcc_pkg::*;
#(
  parameter int COLUMNS   = DEF_COLUMNS,
  parameter int ROWS      = DEF_ROWS,
  parameter int TAB_WIDTH = DEF_TAB_WIDTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  operation,
  input  logic [7:0]  char_code,
  input  logic [10:0] cell_index,
  input  logic        last_of_call,
  output logic        done,
  output logic [15:0] cell_value,
  output logic [6:0]  shown_col,
  output logic [4:0]  shown_row,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [2:0] ADDR_FORE = 3'd0;
  localparam logic [2:0] ADDR_BACK = 3'd4;

  logic [3:0]  fore_color;
  logic [3:0]  back_color;
  logic        cfg_write;
  tcc_cmd_t    cmd;
  tcc_status_t status;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  // Colour registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      fore_color <= 4'd7;
      back_color <= 4'd0;
    end else if (cfg_write) begin
      if (paddr == ADDR_FORE) begin
        fore_color <= pwdata[3:0];
      end
      if (paddr == ADDR_BACK) begin
        back_color <= pwdata[3:0];
      end
    end
  end

  // Register read back.
  always_comb begin
    case (paddr)
      ADDR_FORE: prdata = {28'd0, fore_color};
      ADDR_BACK: prdata = {28'd0, back_color};
      default:   prdata = 32'd0;
    endcase
  end

  tcc_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  tcc_dp #(
    .COLUMNS   (COLUMNS),
    .ROWS      (ROWS),
    .TAB_WIDTH (TAB_WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .operation    (operation),
    .char_code    (char_code),
    .cell_index   (cell_index),
    .last_of_call (last_of_call),
    .fore_color   (fore_color),
    .back_color   (back_color),
    .cell_value   (cell_value),
    .shown_col    (shown_col),
    .shown_row    (shown_row)
  );

endmodule
